FILE: rtl/ifs_pkg.sv
// Package for the injector firing sequencer: field widths, register
// indexes, reset values of the configuration registers and the firing table.
// No dependencies.
package ifs_pkg;

    // Field widths of the tick and result transactions and the debounce register.
    localparam int THR_W   = 12;
    localparam int PULSE_W = 8;
    localparam int CYC_W   = 10;
    localparam int DEB_W   = 8;
    localparam int INJ_N   = 4;
    localparam int INJ_W   = 2;
    localparam int ORD_W   = 2;
    localparam int POS_W   = 2;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Default parameter values.
    localparam int ADC_FULL_SCALE_DEF = 4095;
    localparam int TIME_BITS_DEF      = 32;

    // Register reset values.
    localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 8'd2;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 8'd15;
    localparam logic [CYC_W-1:0]   MIN_CYCLE_RST = 10'd20;
    localparam logic [CYC_W-1:0]   MAX_CYCLE_RST = 10'd200;
    localparam logic [DEB_W-1:0]   DEBOUNCE_RST  = 8'd50;

    // Index of the last firing order.
    localparam logic [ORD_W-1:0] ORDER_LAST = 2'd2;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_PULSE = 3'd0,
        REG_MAX_PULSE = 3'd1,
        REG_MIN_CYCLE = 3'd2,
        REG_MAX_CYCLE = 3'd3,
        REG_DEBOUNCE  = 3'd4
    } cfg_idx_t;

    // Injector fired at a given position of a given firing order.
    // Order 0 is 1-3-4-2, order 1 is 1-2-4-3, order 2 is 1-3-2-4.
    function automatic logic [INJ_W-1:0] fire_seq(input logic [ORD_W-1:0] order,
                                                  input logic [POS_W-1:0] pos);
        logic [INJ_W-1:0] inj;
        inj = 2'd0;
        case (order)
            2'd0:
            begin
                case (pos)
                    2'd0:    inj = 2'd0;
                    2'd1:    inj = 2'd2;
                    2'd2:    inj = 2'd3;
                    default: inj = 2'd1;
                endcase
            end
            2'd1:
            begin
                case (pos)
                    2'd0:    inj = 2'd0;
                    2'd1:    inj = 2'd1;
                    2'd2:    inj = 2'd3;
                    default: inj = 2'd2;
                endcase
            end
            default:
            begin
                case (pos)
                    2'd0:    inj = 2'd0;
                    2'd1:    inj = 2'd2;
                    2'd2:    inj = 2'd1;
                    default: inj = 2'd3;
                endcase
            end
        endcase
        return inj;
    endfunction

endpackage

FILE: rtl/ifs_if.sv
// Valid/ready channel interfaces for the tick and result transactions.
// Depends on ifs_pkg for the field widths.
interface ifs_tick_if;
    logic                       valid;
    logic                       ready;
    logic [ifs_pkg::THR_W-1:0]  throttle_sample;
    logic                       button_level;

    modport source (output valid, output throttle_sample, output button_level,
                    input ready);
    modport sink   (input valid, input throttle_sample, input button_level,
                    output ready);
endinterface

interface ifs_result_if;
    logic                         valid;
    logic                         ready;
    logic [ifs_pkg::INJ_N-1:0]    injector_drive;
    logic                         status_led;
    logic                         fired;
    logic [ifs_pkg::INJ_W-1:0]    fired_injector;
    logic [ifs_pkg::ORD_W-1:0]    firing_order;
    logic [ifs_pkg::CYC_W-1:0]    cycle_time_ms;
    logic [ifs_pkg::PULSE_W-1:0]  pulse_width_ms;

    modport source (output valid, output injector_drive, output status_led,
                    output fired, output fired_injector, output firing_order,
                    output cycle_time_ms, output pulse_width_ms, input ready);
    modport sink   (input valid, input injector_drive, input status_led,
                    input fired, input fired_injector, input firing_order,
                    input cycle_time_ms, input pulse_width_ms, output ready);
endinterface

FILE: rtl/injector_firing_sequencer_top.sv
// Injector firing sequencer top level: throttle mapping, button debounce,
// firing order rotation and injector pulse generation.
// Depends on ifs_pkg and the channel interfaces in ifs_if.sv.
//
// A tick transaction passes through the input, product and result registers before its
// result is valid. Throughput: one tick per cycle while the sink takes results; each
// stage moves when the stage after it is empty or moving, so the sink's ready gates
// only the stages that are full.
// Reset (rst_n, asynchronous, active low) clears all stage valids, the time
// counters, the order and pulse state, and loads the register defaults.
module injector_firing_sequencer_top #(
    parameter int ADC_FULL_SCALE = ifs_pkg::ADC_FULL_SCALE_DEF,
    parameter int TIME_BITS      = ifs_pkg::TIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [ifs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ifs_pkg::CFG_DATA_W-1:0]  cfg_data,
    ifs_tick_if.sink                        tick,
    ifs_result_if.source                    result
);
    import ifs_pkg::*;

    // Arithmetic widths follow from the full-scale value.
    localparam int FS_W = $clog2(ADC_FULL_SCALE + 1);
    localparam int SW   = (FS_W > THR_W) ? FS_W : THR_W;
    localparam int CP_W = CYC_W + SW;
    localparam int PP_W = PULSE_W + SW;
    localparam logic [SW-1:0]   FS_SW = SW'(ADC_FULL_SCALE);

    // Reciprocal of the full scale, rounded up, so that the shifted product
    // equals the truncated quotient for every product the stage can hold.
    localparam int CP_SH = CP_W + FS_W;
    localparam int PP_SH = PP_W + FS_W;
    localparam int CR_W  = CP_W + 2;
    localparam int PR_W  = PP_W + 2;
    localparam int CS_W  = CP_W + CR_W;
    localparam int PS_W  = PP_W + PR_W;
    localparam logic [63:0]     FS_64   = 64'(ADC_FULL_SCALE);
    localparam logic [CR_W-1:0] C_RECIP = CR_W'(((64'd1 << CP_SH) + FS_64 - 64'd1) / FS_64);
    localparam logic [PR_W-1:0] P_RECIP = PR_W'(((64'd1 << PP_SH) + FS_64 - 64'd1) / FS_64);

    // Configuration registers.
    logic [PULSE_W-1:0] min_pulse_reg;
    logic [PULSE_W-1:0] max_pulse_reg;
    logic [CYC_W-1:0]   min_cycle_reg;
    logic [CYC_W-1:0]   max_cycle_reg;
    logic [DEB_W-1:0]   debounce_reg;

    // Pipeline valids and stage handshakes.
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s1_ready;
    logic s2_ready;
    logic s3_ready;
    logic s1_load;
    logic s2_load;
    logic s3_load;

    // Stage payloads.
    logic [THR_W-1:0] thr1_reg;
    logic             btn1_reg;
    logic [CP_W-1:0]  cprod_reg;
    logic [PP_W-1:0]  pprod_reg;
    logic             btn2_reg;

    // Product stage signals.
    logic [SW-1:0]      thr_ext;
    logic [SW-1:0]      thr_clamp;
    logic [SW-1:0]      thr_rest;
    logic [CYC_W-1:0]   span_cycle;
    logic [PULSE_W-1:0] span_pulse;

    // Result stage signals.
    logic [CS_W-1:0]    cscaled;
    logic [PS_W-1:0]    pscaled;
    logic [CP_W-1:0]    cquot;
    logic [PP_W-1:0]    pquot;
    logic [CYC_W-1:0]   cycle_ms;
    logic [PULSE_W-1:0] pulse_ms;

    // Sequencer state.
    logic [TIME_BITS-1:0] tick_count_reg;
    logic [TIME_BITS-1:0] tick_count_next;
    logic [TIME_BITS-1:0] last_fire_reg;
    logic [TIME_BITS-1:0] last_fire_next;
    logic [TIME_BITS-1:0] last_press_reg;
    logic [TIME_BITS-1:0] last_press_next;
    logic                 press_latched_reg;
    logic                 press_latched_next;
    logic [ORD_W-1:0]     order_reg;
    logic [ORD_W-1:0]     order_next;
    logic [POS_W-1:0]     seq_pos_reg;
    logic [POS_W-1:0]     seq_pos_next;
    logic [PULSE_W-1:0]   pulse_rem_reg;
    logic [PULSE_W-1:0]   pulse_rem_next;
    logic [INJ_W-1:0]     active_inj_reg;
    logic [INJ_W-1:0]     active_inj_next;

    // Result register contents.
    logic [INJ_N-1:0]     drive_reg;
    logic [INJ_N-1:0]     drive_next;
    logic                 led_reg;
    logic                 led_next;
    logic                 fired_reg;
    logic                 fired_next;
    logic [INJ_W-1:0]     fired_inj_reg;
    logic [INJ_W-1:0]     fired_inj_next;
    logic [CYC_W-1:0]     cycle_out_reg;
    logic [PULSE_W-1:0]   pulse_out_reg;

    // Scratch values of the result stage.
    logic [TIME_BITS-1:0] now;
    logic [INJ_W-1:0]     fire_inj;
    logic [PULSE_W-1:0]   pulse_load;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pulse_reg <= MIN_PULSE_RST;
            max_pulse_reg <= MAX_PULSE_RST;
            min_cycle_reg <= MIN_CYCLE_RST;
            max_cycle_reg <= MAX_CYCLE_RST;
            debounce_reg  <= DEBOUNCE_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_MIN_PULSE: min_pulse_reg <= cfg_data[PULSE_W-1:0];
                REG_MAX_PULSE: max_pulse_reg <= cfg_data[PULSE_W-1:0];
                REG_MIN_CYCLE: min_cycle_reg <= cfg_data[CYC_W-1:0];
                REG_MAX_CYCLE: max_cycle_reg <= cfg_data[CYC_W-1:0];
                REG_DEBOUNCE:  debounce_reg  <= cfg_data[DEB_W-1:0];
                default:       ;
            endcase
        end
    end

    // A stage takes new data when it is empty or its contents move on.
    assign s3_ready = !s3_valid_reg || result.ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s1_load  = tick.valid && s1_ready;
    assign s2_load  = s1_valid_reg && s2_ready;
    assign s3_load  = s2_valid_reg && s3_ready;
    assign tick.ready = s1_ready;

    // Stage valids.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= tick.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Input register.
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            thr1_reg <= tick.throttle_sample;
            btn1_reg <= tick.button_level;
        end
    end

    // Clamp the throttle to full scale and form the spans; a negative span is zero.
    always_comb
    begin
        thr_ext    = SW'(thr1_reg);
        thr_clamp  = (thr_ext > FS_SW) ? FS_SW : thr_ext;
        thr_rest   = FS_SW - thr_clamp;
        span_cycle = (max_cycle_reg > min_cycle_reg) ? (max_cycle_reg - min_cycle_reg)
                                                     : '0;
        span_pulse = (max_pulse_reg > min_pulse_reg) ? (max_pulse_reg - min_pulse_reg)
                                                     : '0;
    end

    // Product register.
    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            cprod_reg <= CP_W'(span_cycle) * CP_W'(thr_rest);
            pprod_reg <= PP_W'(span_pulse) * PP_W'(thr_clamp);
            btn2_reg  <= btn1_reg;
        end
    end

    // Scale by full scale through the reciprocal; the quotients never exceed the spans.
    always_comb
    begin
        cscaled  = CS_W'(cprod_reg) * CS_W'(C_RECIP);
        pscaled  = PS_W'(pprod_reg) * PS_W'(P_RECIP);
        cquot    = CP_W'(cscaled >> CP_SH);
        pquot    = PP_W'(pscaled >> PP_SH);
        cycle_ms = CYC_W'(cquot) + min_cycle_reg;
        pulse_ms = PULSE_W'(pquot) + min_pulse_reg;
    end

    // Button debounce, firing check and pulse countdown for one tick.
    always_comb
    begin
        now                = tick_count_reg;
        tick_count_next    = tick_count_reg + 1'b1;
        last_fire_next     = last_fire_reg;
        last_press_next    = last_press_reg;
        press_latched_next = press_latched_reg;
        order_next         = order_reg;
        seq_pos_next       = seq_pos_reg;
        pulse_rem_next     = pulse_rem_reg;
        active_inj_next    = active_inj_reg;
        fired_next         = 1'b0;
        fired_inj_next     = '0;
        drive_next         = '0;
        led_next           = 1'b0;
        pulse_load         = pulse_ms;

        // A press counts only once per hold and after the debounce time.
        if (!btn2_reg)
        begin
            if (!press_latched_reg &&
                ((now - last_press_reg) > TIME_BITS'(debounce_reg)))
            begin
                press_latched_next = 1'b1;
                order_next         = (order_reg == ORDER_LAST) ? '0 : order_reg + 1'b1;
                last_press_next    = now;
            end
        end
        else
        begin
            press_latched_next = 1'b0;
        end

        // Fire the next injector of the order once the cycle time has passed.
        fire_inj = fire_seq(order_next, seq_pos_reg);
        if ((now - last_fire_reg) >= TIME_BITS'(cycle_ms))
        begin
            last_fire_next  = now;
            fired_next      = 1'b1;
            fired_inj_next  = fire_inj;
            active_inj_next = fire_inj;
            seq_pos_next    = seq_pos_reg + 1'b1;
            pulse_rem_next  = pulse_load;
        end

        // Drive the active injector while pulse time remains.
        if (pulse_rem_next != '0)
        begin
            drive_next     = INJ_N'(1) << active_inj_next;
            led_next       = 1'b1;
            pulse_rem_next = pulse_rem_next - 1'b1;
        end
    end

    // Sequencer state advances once per tick reaching the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg    <= '0;
            last_fire_reg     <= '0;
            last_press_reg    <= '0;
            press_latched_reg <= 1'b0;
            order_reg         <= '0;
            seq_pos_reg       <= '0;
            pulse_rem_reg     <= '0;
            active_inj_reg    <= '0;
        end
        else if (s3_load)
        begin
            tick_count_reg    <= tick_count_next;
            last_fire_reg     <= last_fire_next;
            last_press_reg    <= last_press_next;
            press_latched_reg <= press_latched_next;
            order_reg         <= order_next;
            seq_pos_reg       <= seq_pos_next;
            pulse_rem_reg     <= pulse_rem_next;
            active_inj_reg    <= active_inj_next;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (s3_load)
        begin
            drive_reg     <= drive_next;
            led_reg       <= led_next;
            fired_reg     <= fired_next;
            fired_inj_reg <= fired_inj_next;
            cycle_out_reg <= cycle_ms;
            pulse_out_reg <= pulse_ms;
        end
    end

    // Result transaction outputs; the order register already holds this tick's order.
    assign result.valid          = s3_valid_reg;
    assign result.injector_drive = drive_reg;
    assign result.status_led     = led_reg;
    assign result.fired          = fired_reg;
    assign result.fired_injector = fired_inj_reg;
    assign result.firing_order   = order_reg;
    assign result.cycle_time_ms  = cycle_out_reg;
    assign result.pulse_width_ms = pulse_out_reg;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for injector_firing_sequencer_top: directed ticks, then
// random tick traffic under several register settings, each result checked against a
// cycle-free predictor or a golden value. Depends on ifs_pkg and ifs_if.sv channels.
module testbench;

    import ifs_pkg::*;

    localparam int TIME_BITS   = TIME_BITS_DEF;
    localparam int FULL_SCALE  = ADC_FULL_SCALE_DEF;
    localparam int PIPE_DEPTH  = 3;
    localparam int DRAIN_PAD   = PIPE_DEPTH + 3;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_LEN    = 150;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 85;
    localparam int HOLD_PHASE  = 4;
    localparam int PAUSE_PHASE = 2;

    // Register indexes the block does not decode; writes to them must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    // Injector sequence of each firing order: 1-3-4-2, 1-2-4-3, 1-3-2-4 (zero based).
    localparam logic [0:2][0:3][INJ_W-1:0] FIRING_TABLE = {
        2'd0, 2'd2, 2'd3, 2'd1,
        2'd0, 2'd1, 2'd3, 2'd2,
        2'd0, 2'd2, 2'd1, 2'd3
    };

    typedef struct packed {
        logic [INJ_N-1:0]   injector_drive;
        logic               status_led;
        logic               fired;
        logic [INJ_W-1:0]   fired_injector;
        logic [ORD_W-1:0]   firing_order;
        logic [CYC_W-1:0]   cycle_time_ms;
        logic [PULSE_W-1:0] pulse_width_ms;
    } tick_outcome_t;

    typedef enum logic {
        ROW_TICK,
        ROW_REG
    } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [THR_W-1:0]      throttle;
        logic                  button;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_data;
        bit                    has_golden;
        tick_outcome_t         golden;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ifs_tick_if   tick_ch();
    ifs_result_if res_ch();

    injector_firing_sequencer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .tick         (tick_ch),
        .result       (res_ch)
    );

    // Predictor copy of the registers.
    logic [PULSE_W-1:0] cfg_min_pulse = MIN_PULSE_RST;
    logic [PULSE_W-1:0] cfg_max_pulse = MAX_PULSE_RST;
    logic [CYC_W-1:0]   cfg_min_cycle = MIN_CYCLE_RST;
    logic [CYC_W-1:0]   cfg_max_cycle = MAX_CYCLE_RST;
    logic [DEB_W-1:0]   cfg_debounce  = DEBOUNCE_RST;

    // Predictor copy of the sequencer state.
    logic [TIME_BITS-1:0] ms_clock      = '0;
    logic [TIME_BITS-1:0] last_fire_ms  = '0;
    logic [TIME_BITS-1:0] last_press_ms = '0;
    logic                 press_held    = 1'b0;
    logic [ORD_W-1:0]     order_sel     = '0;
    logic [POS_W-1:0]     seq_pos       = '0;
    logic [PULSE_W-1:0]   pulse_left    = '0;
    logic [INJ_W-1:0]     active_inj    = '0;

    tick_outcome_t pending_outcomes[$];
    plan_row_t     directed_plan[$];
    int            mismatches    = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    bit            hold_armed    = 1'b0;
    logic          btn_now       = 1'b1;
    int            btn_left      = 0;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Map the throttle, handle the button, fire and age the pulse for one tick.
    function automatic tick_outcome_t fire_tick_outcome(input logic [THR_W-1:0] thr,
                                                        input logic btn);
        tick_outcome_t        res;
        int unsigned          thr_i;
        int unsigned          span_c;
        int unsigned          span_p;
        int unsigned          cyc;
        int unsigned          pw;
        logic [TIME_BITS-1:0] gap_ms;
        res    = '0;
        thr_i  = 32'(thr);
        if (thr_i > FULL_SCALE)
            thr_i = FULL_SCALE;
        span_c = (cfg_max_cycle > cfg_min_cycle) ? cfg_max_cycle - cfg_min_cycle : 0;
        span_p = (cfg_max_pulse > cfg_min_pulse) ? cfg_max_pulse - cfg_min_pulse : 0;
        cyc    = span_c * (FULL_SCALE - thr_i) / FULL_SCALE + cfg_min_cycle;
        pw     = span_p * thr_i / FULL_SCALE + cfg_min_pulse;

        // Button first, so an accepted press steers this tick's firing.
        if (!btn)
        begin
            gap_ms = ms_clock - last_press_ms;
            if (!press_held && gap_ms > cfg_debounce)
            begin
                press_held    = 1'b1;
                order_sel     = (order_sel == ORDER_LAST) ? '0 : order_sel + 1'b1;
                last_press_ms = ms_clock;
            end
        end
        else
        begin
            press_held = 1'b0;
        end

        // Fire once the cycle time has elapsed; a new firing restarts the pulse.
        gap_ms = ms_clock - last_fire_ms;
        if (gap_ms >= cyc)
        begin
            last_fire_ms       = ms_clock;
            res.fired          = 1'b1;
            res.fired_injector = FIRING_TABLE[order_sel][seq_pos];
            active_inj         = res.fired_injector;
            seq_pos            = seq_pos + 1'b1;
            pulse_left         = pw[PULSE_W-1:0];
        end

        if (pulse_left != 0)
        begin
            res.injector_drive = INJ_N'(1) << active_inj;
            res.status_led     = 1'b1;
            pulse_left         = pulse_left - 1'b1;
        end

        ms_clock           = ms_clock + 1'b1;
        res.firing_order   = order_sel;
        res.cycle_time_ms  = cyc[CYC_W-1:0];
        res.pulse_width_ms = pw[PULSE_W-1:0];
        return res;
    endfunction

    function automatic void add_tick(input logic [THR_W-1:0] thr, input logic btn,
                                     input bit has_golden = 1'b0,
                                     input tick_outcome_t golden = '0);
        plan_row_t row;
        row            = '{kind: ROW_TICK, default: '0};
        row.kind       = ROW_TICK;
        row.throttle   = thr;
        row.button     = btn;
        row.has_golden = has_golden;
        row.golden     = golden;
        directed_plan.push_back(row);
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        plan_row_t row;
        row           = '{kind: ROW_REG, default: '0};
        row.kind      = ROW_REG;
        row.reg_index = idx;
        row.reg_data  = data;
        directed_plan.push_back(row);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // One register write; the block is idle whenever this is called.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_MIN_PULSE: cfg_min_pulse = data[PULSE_W-1:0];
            REG_MAX_PULSE: cfg_max_pulse = data[PULSE_W-1:0];
            REG_MIN_CYCLE: cfg_min_cycle = data[CYC_W-1:0];
            REG_MAX_CYCLE: cfg_max_cycle = data[CYC_W-1:0];
            REG_DEBOUNCE:  cfg_debounce  = data[DEB_W-1:0];
            default:       ;
        endcase
    endtask

    // Offer one tick transaction and record its outcome once it is taken.
    task automatic send_tick(input logic [THR_W-1:0] thr, input logic btn,
                             input bit has_golden, input tick_outcome_t golden);
        tick_outcome_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            tick_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tick_ch.valid           <= 1'b1;
        tick_ch.throttle_sample <= thr;
        tick_ch.button_level    <= btn;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        predicted = fire_tick_outcome(thr, btn);
        pending_outcomes.push_back(has_golden ? golden : predicted);
    endtask

    // Stop offering, let every outstanding result arrive, then let the pipe settle.
    task automatic wait_drained();
        tick_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_outcomes.size() != 0);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    // Random ticks; the button is held in presses and releases of random length.
    task automatic run_traffic(input int count, input bit pause_midway);
        logic [THR_W-1:0] thr;
        for (int i = 0; i < count; i++)
        begin
            if (pause_midway && i == count / 2)
                wait_drained();
            if (btn_left == 0)
            begin
                btn_now  = ~btn_now;
                btn_left = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
            end
            btn_left--;
            case ($urandom_range(0, 7))
                0:       thr = '0;
                1:       thr = '1;
                default: thr = THR_W'($urandom_range(0, FULL_SCALE));
            endcase
            send_tick(thr, btn_now, 1'b0, '0);
        end
    endtask

    // Result side: check each transaction, stall at random or for a long hold.
    initial
    begin
        int hold_left;
        hold_left    = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    $error("result transaction with no tick waiting for it");
                    mismatches++;
                end
                else
                begin
                    tick_outcome_t want;
                    want = pending_outcomes.pop_front();
                    check_field("injector_drive", 32'(want.injector_drive),
                                32'(res_ch.injector_drive));
                    check_field("status_led", 32'(want.status_led),
                                32'(res_ch.status_led));
                    check_field("fired", 32'(want.fired), 32'(res_ch.fired));
                    check_field("fired_injector", 32'(want.fired_injector),
                                32'(res_ch.fired_injector));
                    check_field("firing_order", 32'(want.firing_order),
                                32'(res_ch.firing_order));
                    check_field("cycle_time_ms", 32'(want.cycle_time_ms),
                                32'(res_ch.cycle_time_ms));
                    check_field("pulse_width_ms", 32'(want.pulse_width_ms),
                                32'(res_ch.pulse_width_ms));
                end
            end
            if (hold_armed)
            begin
                hold_armed = 1'b0;
                hold_left  = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: too long without any transaction on either channel.
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    // Stimulus: reset, directed table, then random phases.
    initial
    begin
        rst_n                   = 1'b0;
        cfg_write_en            = 1'b0;
        cfg_index               = '0;
        cfg_data                = '0;
        tick_ch.valid           = 1'b0;
        tick_ch.throttle_sample = '0;
        tick_ch.button_level    = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Writes to undecoded indexes must leave the defaults alone.
        for (int idx = REG_UNMAPPED_LO; idx <= REG_UNMAPPED_HI; idx++)
            add_reg(CFG_IDX_W'(idx), '1);
        // Defaults at both throttle extremes; a press this early is inside debounce.
        add_tick(12'd0, 1'b1, 1'b1, '{4'd0, 1'b0, 1'b0, 2'd0, 2'd0, 10'd200, 8'd2});
        add_tick(12'd4095, 1'b1, 1'b1, '{4'd0, 1'b0, 1'b0, 2'd0, 2'd0, 10'd20, 8'd15});
        add_tick(12'd4095, 1'b0, 1'b1, '{4'd0, 1'b0, 1'b0, 2'd0, 2'd0, 10'd20, 8'd15});
        add_tick(12'hAAA, 1'b1);
        add_tick(12'h555, 1'b0);
        // Zero cycle fires every tick; zero pulse fires with nothing driven.
        add_reg(REG_MIN_CYCLE, '0);
        add_reg(REG_MAX_CYCLE, '0);
        add_reg(REG_MIN_PULSE, '0);
        add_reg(REG_MAX_PULSE, '0);
        add_reg(REG_DEBOUNCE, '0);
        add_tick(12'd4095, 1'b1, 1'b1, '{4'd0, 1'b0, 1'b1, 2'd0, 2'd0, 10'd0, 8'd0});
        // Presses walk through all three orders and wrap; a held press counts once.
        add_tick(12'd0, 1'b0);
        add_tick(12'd0, 1'b0);
        add_tick(12'd0, 1'b1);
        add_tick(12'd0, 1'b0);
        add_tick(12'd0, 1'b1);
        add_tick(12'd0, 1'b0);
        // Minimum above maximum: both spans clamp to zero.
        add_reg(REG_MIN_PULSE, 10'd255);
        add_reg(REG_MAX_PULSE, 10'd0);
        add_reg(REG_MIN_CYCLE, 10'd1023);
        add_reg(REG_MAX_CYCLE, 10'd1);
        add_reg(REG_DEBOUNCE, 10'd255);
        add_tick(12'd2048, 1'b1, 1'b1, '{4'd0, 1'b0, 1'b0, 2'd0, 2'd0, 10'd1023, 8'd255});
        // Full spans: long pulse, then a refire cuts it short.
        add_reg(REG_MIN_PULSE, 10'd0);
        add_reg(REG_MAX_PULSE, 10'd255);
        add_reg(REG_MIN_CYCLE, 10'd1);
        add_reg(REG_MAX_CYCLE, 10'd1023);
        add_tick(12'd4095, 1'b1);
        add_tick(12'd0, 1'b1);
        add_tick(12'hFFF, 1'b0);

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == ROW_REG)
            begin
                wait_drained();
                write_reg(directed_plan[i].reg_index, directed_plan[i].reg_data);
            end
            else
            begin
                send_tick(directed_plan[i].throttle, directed_plan[i].button,
                          directed_plan[i].has_golden, directed_plan[i].golden);
            end
        end

        // Random phases: each with its own settings and idling pattern.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            case (ph / 2)
                0:
                begin
                    send_idle_pct = 32;
                    recv_idle_pct = 54;
                end
                1:
                begin
                    send_idle_pct = 54;
                    recv_idle_pct = 32;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (ph)
                1:
                begin
                    write_reg(REG_MIN_PULSE, 10'd0);
                    write_reg(REG_MAX_PULSE, 10'd255);
                    write_reg(REG_MIN_CYCLE, 10'd0);
                    write_reg(REG_MAX_CYCLE, 10'd60);
                    write_reg(REG_DEBOUNCE, 10'd0);
                end
                3:
                begin
                    write_reg(REG_MIN_PULSE, 10'd255);
                    write_reg(REG_MAX_PULSE, 10'd255);
                    write_reg(REG_MIN_CYCLE, 10'd3);
                    write_reg(REG_MAX_CYCLE, 10'd9);
                    write_reg(REG_DEBOUNCE, 10'd255);
                end
                5:
                begin
                    write_reg(REG_MIN_PULSE, CFG_DATA_W'(MIN_PULSE_RST));
                    write_reg(REG_MAX_PULSE, CFG_DATA_W'(MAX_PULSE_RST));
                    write_reg(REG_MIN_CYCLE, CFG_DATA_W'(MIN_CYCLE_RST));
                    write_reg(REG_MAX_CYCLE, CFG_DATA_W'(MAX_CYCLE_RST));
                    write_reg(REG_DEBOUNCE, CFG_DATA_W'(DEBOUNCE_RST));
                end
                default:
                begin
                    // Short cycles keep firings frequent; upper data bits are junk.
                    write_reg(REG_MIN_PULSE, CFG_DATA_W'($urandom_range(0, 1023)));
                    write_reg(REG_MAX_PULSE, CFG_DATA_W'($urandom_range(0, 1023)));
                    write_reg(REG_MIN_CYCLE, CFG_DATA_W'($urandom_range(0, 12)));
                    write_reg(REG_MAX_CYCLE, CFG_DATA_W'($urandom_range(0, 48)));
                    write_reg(REG_DEBOUNCE,
                              CFG_DATA_W'(($urandom_range(0, 3) << 8) |
                                          $urandom_range(0, 30)));
                end
            endcase
            if (ph == HOLD_PHASE)
                hold_armed = 1'b1;
            run_traffic(PHASE_ITEMS, ph == PAUSE_PHASE);
        end

        wait_drained();
        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
rtl/ifs_pkg.sv
rtl/ifs_if.sv
rtl/injector_firing_sequencer_top.sv
tb/testbench.sv
